>>> src/lav_pkg.sv
// lav_pkg: widths, payload structs and shared rounding helpers for the
// look-at view matrix unit; no dependencies
package lav_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  // normalizer input width: holds target minus eye
  localparam int NV_W      = 35;
  // magnitude width after leading-one alignment into [2^30, 2^31)
  localparam int MAG_W     = 31;
  // unit vector components and cross products, with headroom
  localparam int UNIT_W    = FRAC_BITS + 3;
  // quotient bits of the normalizer divide
  localparam int QW        = FRAC_BITS + 2;
  localparam int SQ_STEPS  = 32;
  localparam int ACC_W     = 64;
  localparam int NORM_LAT  = SQ_STEPS + QW + 8;
  localparam int LAT       = 2 * NORM_LAT + 7;
  localparam int PROD_A    = 2 * UNIT_W + 1;
  localparam int PROD_B    = UNIT_W + WORD_W + 2;
  localparam int RND_W     = (PROD_A > PROD_B) ? PROD_A : PROD_B;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [NV_W-1:0]   nv_t;
  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef word_t [2:0] wvec_t;
  typedef nv_t   [2:0] nvec_t;
  typedef unit_t [2:0] uvec_t;

  typedef struct packed {
    word_t eye_x;
    word_t eye_y;
    word_t eye_z;
    word_t target_x;
    word_t target_y;
    word_t target_z;
    word_t upref_x;
    word_t upref_y;
    word_t upref_z;
  } in_item_t;

  typedef struct packed {
    word_t side_x;
    word_t side_y;
    word_t side_z;
    word_t trueup_x;
    word_t trueup_y;
    word_t trueup_z;
    word_t back_x;
    word_t back_y;
    word_t back_z;
    word_t shift_x;
    word_t shift_y;
    word_t shift_z;
  } out_item_t;

  typedef struct packed {
    wvec_t eye;
    nvec_t dir;
    nvec_t upr;
  } mid_t;

  localparam logic signed [RND_W-1:0] W_MAX =
    $signed((RND_W'(1) << (WORD_W - 1)) - RND_W'(1));
  localparam logic signed [RND_W-1:0] W_MIN = -W_MAX - RND_W'(1);

  // shift right by FRAC_BITS, rounding half away from zero
  function automatic logic signed [RND_W-1:0] rnd_shr(input logic signed [RND_W-1:0] x);
    logic [RND_W-1:0] m;
    logic [RND_W-1:0] r;
    m = x[RND_W-1] ? (~x + 1'b1) : x;
    r = (m + (RND_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[RND_W-1] ? $signed(~r + 1'b1) : $signed(r);
  endfunction

  function automatic word_t sat_word(input logic signed [RND_W-1:0] x);
    word_t w;
    if (x > W_MAX) begin
      w = W_MAX[WORD_W-1:0];
    end else if (x < W_MIN) begin
      w = W_MIN[WORD_W-1:0];
    end else begin
      w = x[WORD_W-1:0];
    end
    return w;
  endfunction

endpackage

>>> src/lav_norm.sv
// lav_norm: pipelined 3-vector normalizer (align, squares, bit-serial
// square root stages, restoring divide stages); uses lav_pkg
module lav_norm (
  input  logic          clk,
  input  logic          en,
  input  lav_pkg::nvec_t v,
  output lav_pkg::uvec_t o
);
  import lav_pkg::*;

  localparam int RS_W = $clog2(NV_W - MAG_W + 1);

  typedef struct packed {
    logic [2:0][MAG_W-1:0] m;
    logic [2:0]            sg;
    logic                  z;
  } nside_t;

  logic [2:0][NV_W-1:0]  mag_w;
  logic [NV_W-1:0]       mx_w;
  logic [2:0][NV_W-1:0]  m0_r;
  logic [NV_W-1:0]       mx0_r;
  logic [2:0]            sg0_r, sg1_r, sg2_r, sg3_r;
  logic                  z1_r, z2_r, z3_r;
  logic [RS_W-1:0]       rs_w;
  logic [2:0][MAG_W-1:0] m1_r, m2_r, m3_r, a2_w, a3_w;
  logic [MAG_W-1:0]      mx1_r, mx2_r, x2_w, x3_w;
  logic [2:0][2*MAG_W-1:0] sq4_r;
  nside_t                sd4_r;

  logic [ACC_W-1:0] rem_r [SQ_STEPS+1];
  logic [ACC_W-1:0] res_r [SQ_STEPS+1];
  nside_t           sqs_r [SQ_STEPS+1];
  logic [ACC_W-1:0] rem_n [SQ_STEPS];
  logic [ACC_W-1:0] res_n [SQ_STEPS];

  logic [2:0][ACC_W-1:0] drem_r [QW+1];
  logic [2:0][QW-1:0]    q_r    [QW+1];
  logic [ACC_W-1:0]      dlen_r [QW+1];
  nside_t                dvs_r  [QW+1];
  logic [2:0][ACC_W-1:0] drem_n [QW];
  logic [2:0][QW-1:0]    q_n    [QW];
  uvec_t                 o_r;

  // magnitudes and largest one
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i] = v[i][NV_W-1] ? (~v[i] + 1'b1) : v[i];
    end
    mx_w = mag_w[0];
    for (int i = 1; i < 3; i++) begin
      if (mag_w[i] > mx_w) begin
        mx_w = mag_w[i];
      end
    end
  end

  // right shift amount to bring the largest below 2^31
  always_comb begin
    rs_w = '0;
    for (int b = MAG_W; b < NV_W; b++) begin
      if (mx0_r[b]) begin
        rs_w = RS_W'(b - MAG_W + 1);
      end
    end
  end

  // left alignment, coarse steps then fine steps
  always_comb begin
    a2_w = m1_r;
    x2_w = mx1_r;
    if (x2_w[MAG_W-1 -: 16] == '0) begin
      x2_w = x2_w << 16;
      for (int i = 0; i < 3; i++) a2_w[i] = a2_w[i] << 16;
    end
    if (x2_w[MAG_W-1 -: 8] == '0) begin
      x2_w = x2_w << 8;
      for (int i = 0; i < 3; i++) a2_w[i] = a2_w[i] << 8;
    end
    a3_w = m2_r;
    x3_w = mx2_r;
    if (x3_w[MAG_W-1 -: 4] == '0) begin
      x3_w = x3_w << 4;
      for (int i = 0; i < 3; i++) a3_w[i] = a3_w[i] << 4;
    end
    if (x3_w[MAG_W-1 -: 2] == '0) begin
      x3_w = x3_w << 2;
      for (int i = 0; i < 3; i++) a3_w[i] = a3_w[i] << 2;
    end
    if (!x3_w[MAG_W-1]) begin
      x3_w = x3_w << 1;
      for (int i = 0; i < 3; i++) a3_w[i] = a3_w[i] << 1;
    end
  end

  // one result bit of the square root per stage
  always_comb begin
    logic [ACC_W-1:0] bt;
    logic [ACC_W-1:0] t;
    for (int j = 0; j < SQ_STEPS; j++) begin
      bt = ACC_W'(1) << (2 * (SQ_STEPS - 1 - j));
      t  = res_r[j] + bt;
      if (rem_r[j] >= t) begin
        rem_n[j] = rem_r[j] - t;
        res_n[j] = (res_r[j] >> 1) + bt;
      end else begin
        rem_n[j] = rem_r[j];
        res_n[j] = res_r[j] >> 1;
      end
    end
  end

  // one quotient bit per stage, three lanes share the divisor
  always_comb begin
    logic [ACC_W-1:0] d;
    for (int k = 0; k < QW; k++) begin
      d = dlen_r[k] << (QW - 1 - k);
      for (int i = 0; i < 3; i++) begin
        drem_n[k][i] = drem_r[k][i];
        q_n[k][i]    = q_r[k][i];
        if (drem_r[k][i] >= d) begin
          drem_n[k][i] = drem_r[k][i] - d;
          q_n[k][i][QW-1-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r  <= mag_w;
      mx0_r <= mx_w;
      for (int i = 0; i < 3; i++) sg0_r[i] <= v[i][NV_W-1];
      for (int i = 0; i < 3; i++) m1_r[i] <= MAG_W'(m0_r[i] >> rs_w);
      mx1_r <= MAG_W'(mx0_r >> rs_w);
      z1_r  <= (mx0_r == '0);
      sg1_r <= sg0_r;
      m2_r  <= a2_w;
      mx2_r <= x2_w;
      z2_r  <= z1_r;
      sg2_r <= sg1_r;
      m3_r  <= a3_w;
      z3_r  <= z2_r;
      sg3_r <= sg2_r;
      for (int i = 0; i < 3; i++) sq4_r[i] <= m3_r[i] * m3_r[i];
      sd4_r <= '{m: m3_r, sg: sg3_r, z: z3_r};
      rem_r[0] <= ACC_W'(sq4_r[0]) + ACC_W'(sq4_r[1]) + ACC_W'(sq4_r[2]);
      res_r[0] <= '0;
      sqs_r[0] <= sd4_r;
      for (int j = 0; j < SQ_STEPS; j++) begin
        rem_r[j+1] <= rem_n[j];
        res_r[j+1] <= res_n[j];
        sqs_r[j+1] <= sqs_r[j];
      end
      // rounded dividend: (m << frac) + len / 2
      for (int i = 0; i < 3; i++) begin
        drem_r[0][i] <= (ACC_W'(sqs_r[SQ_STEPS].m[i]) << FRAC_BITS) +
                        (res_r[SQ_STEPS] >> 1);
      end
      q_r[0]    <= '0;
      dlen_r[0] <= res_r[SQ_STEPS];
      dvs_r[0]  <= sqs_r[SQ_STEPS];
      for (int k = 0; k < QW; k++) begin
        drem_r[k+1] <= drem_n[k];
        q_r[k+1]    <= q_n[k];
        dlen_r[k+1] <= dlen_r[k];
        dvs_r[k+1]  <= dvs_r[k];
      end
      for (int i = 0; i < 3; i++) begin
        if (dvs_r[QW].z) begin
          o_r[i] <= '0;
        end else if (dvs_r[QW].sg[i]) begin
          o_r[i] <= -$signed(UNIT_W'(q_r[QW][i]));
        end else begin
          o_r[i] <= $signed(UNIT_W'(q_r[QW][i]));
        end
      end
    end
  end

  assign o = o_r;

endmodule

>>> src/lav_front.sv
// lav_front: input register stage, forms the view direction and widens the
// up vector for the normalizers; uses lav_pkg
module lav_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  lav_pkg::in_item_t in_item,
  output logic              mid_push,
  output lav_pkg::mid_t     mid_item,
  input  logic              mid_full
);
  import lav_pkg::*;

  logic  vld_r, vld_nxt;
  mid_t  item_r;
  logic  accept;

  assign in_full  = vld_r && mid_full;
  assign accept   = in_push && !in_full;
  assign mid_push = vld_r && !mid_full;
  assign mid_item = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (mid_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.eye[0] <= in_item.eye_x;
      item_r.eye[1] <= in_item.eye_y;
      item_r.eye[2] <= in_item.eye_z;
      item_r.dir[0] <= NV_W'(in_item.target_x) - NV_W'(in_item.eye_x);
      item_r.dir[1] <= NV_W'(in_item.target_y) - NV_W'(in_item.eye_y);
      item_r.dir[2] <= NV_W'(in_item.target_z) - NV_W'(in_item.eye_z);
      item_r.upr[0] <= NV_W'(in_item.upref_x);
      item_r.upr[1] <= NV_W'(in_item.upref_y);
      item_r.upr[2] <= NV_W'(in_item.upref_z);
    end
  end

endmodule

>>> src/lav_fifo.sv
// lav_fifo: two-entry queue between the front and the back pipeline;
// uses lav_pkg
module lav_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lav_pkg::mid_t wr_item,
  output logic          full,
  input  logic          pop,
  output lav_pkg::mid_t rd_item,
  output logic          empty
);
  import lav_pkg::*;

  mid_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign rd_item = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule

>>> src/lav_back.sv
// lav_back: stalling pipeline with three normalizers, two cross products,
// three dot products and a two-entry result queue; uses lav_pkg, lav_norm
module lav_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mid_empty,
  output logic               mid_pop,
  input  lav_pkg::mid_t      mid_item,
  output logic               out_empty,
  input  logic               out_pop,
  output lav_pkg::out_item_t out_item
);
  import lav_pkg::*;

  localparam int PW = 2 * UNIT_W;
  localparam int DW = UNIT_W + WORD_W;

  typedef struct packed {
    uvec_t s;
    uvec_t u;
    uvec_t f;
  } rot_t;

  logic      vld_r [LAT+1];
  logic      en;
  wvec_t     eye0_r;
  nvec_t     dir0_r, upr0_r;
  uvec_t     n_w, f_w, s_w;
  logic signed [PW-1:0] p1_r [6];
  logic signed [PW-1:0] p2_r [6];
  nvec_t     sr_r;
  uvec_t     u_r;
  uvec_t     fd_r [NORM_LAT+4];
  uvec_t     sd_r [2];
  wvec_t     ed_r [2*NORM_LAT+4];
  uvec_t     sv, fv, f2;
  wvec_t     ev;
  logic signed [DW-1:0] dp_r [3][3];
  logic signed [RND_W-1:0] ds_r [3];
  rot_t      rot5_r, rot6_r;
  out_item_t fin_r;

  out_item_t  oq_r [2];
  logic       oq_wp_r, oq_rp_r;
  logic [1:0] oq_cnt_r, oq_cnt_nxt;
  logic       oq_push, oq_pop;

  assign en      = !(vld_r[LAT] && (oq_cnt_r == 2'd2));
  assign mid_pop = en && !mid_empty;

  lav_norm u_norm_n (.clk(clk), .en(en), .v(upr0_r), .o(n_w));
  lav_norm u_norm_f (.clk(clk), .en(en), .v(dir0_r), .o(f_w));
  lav_norm u_norm_s (.clk(clk), .en(en), .v(sr_r),   .o(s_w));

  assign f2 = fd_r[NORM_LAT+1];
  assign sv = sd_r[1];
  assign fv = fd_r[NORM_LAT+3];
  assign ev = ed_r[2*NORM_LAT+3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= mid_pop;
      for (int k = 1; k <= LAT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye0_r <= mid_item.eye;
      dir0_r <= mid_item.dir;
      upr0_r <= mid_item.upr;
      // f x n
      p1_r[0] <= f_w[1] * n_w[2];
      p1_r[1] <= f_w[2] * n_w[1];
      p1_r[2] <= f_w[2] * n_w[0];
      p1_r[3] <= f_w[0] * n_w[2];
      p1_r[4] <= f_w[0] * n_w[1];
      p1_r[5] <= f_w[1] * n_w[0];
      for (int i = 0; i < 3; i++) begin
        sr_r[i] <= NV_W'(rnd_shr(RND_W'(p1_r[2*i]) - RND_W'(p1_r[2*i+1])));
      end
      fd_r[0] <= f_w;
      for (int k = 1; k < NORM_LAT + 4; k++) fd_r[k] <= fd_r[k-1];
      ed_r[0] <= eye0_r;
      for (int k = 1; k < 2 * NORM_LAT + 4; k++) ed_r[k] <= ed_r[k-1];
      // s x f
      p2_r[0] <= s_w[1] * f2[2];
      p2_r[1] <= s_w[2] * f2[1];
      p2_r[2] <= s_w[2] * f2[0];
      p2_r[3] <= s_w[0] * f2[2];
      p2_r[4] <= s_w[0] * f2[1];
      p2_r[5] <= s_w[1] * f2[0];
      for (int i = 0; i < 3; i++) begin
        u_r[i] <= UNIT_W'(rnd_shr(RND_W'(p2_r[2*i]) - RND_W'(p2_r[2*i+1])));
      end
      sd_r[0] <= s_w;
      sd_r[1] <= sd_r[0];
      // dot products against the eye
      for (int i = 0; i < 3; i++) begin
        dp_r[0][i] <= sv[i]  * ev[i];
        dp_r[1][i] <= u_r[i] * ev[i];
        dp_r[2][i] <= fv[i]  * ev[i];
      end
      rot5_r <= '{s: sv, u: u_r, f: fv};
      for (int j = 0; j < 3; j++) begin
        ds_r[j] <= rnd_shr(RND_W'(dp_r[j][0]) + RND_W'(dp_r[j][1]) + RND_W'(dp_r[j][2]));
      end
      rot6_r <= rot5_r;
      fin_r.side_x   <= WORD_W'(rot6_r.s[0]);
      fin_r.side_y   <= WORD_W'(rot6_r.s[1]);
      fin_r.side_z   <= WORD_W'(rot6_r.s[2]);
      fin_r.trueup_x <= WORD_W'(rot6_r.u[0]);
      fin_r.trueup_y <= WORD_W'(rot6_r.u[1]);
      fin_r.trueup_z <= WORD_W'(rot6_r.u[2]);
      fin_r.back_x   <= WORD_W'(-rot6_r.f[0]);
      fin_r.back_y   <= WORD_W'(-rot6_r.f[1]);
      fin_r.back_z   <= WORD_W'(-rot6_r.f[2]);
      fin_r.shift_x  <= sat_word(-ds_r[0]);
      fin_r.shift_y  <= sat_word(-ds_r[1]);
      fin_r.shift_z  <= sat_word(ds_r[2]);
    end
  end

  // result queue
  assign oq_push   = en && vld_r[LAT];
  assign oq_pop    = out_pop && (oq_cnt_r != 2'd0);
  assign out_empty = (oq_cnt_r == 2'd0);
  assign out_item  = oq_r[oq_rp_r];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 2'd1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= 2'd0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) oq_wp_r <= ~oq_wp_r;
      if (oq_pop)  oq_rp_r <= ~oq_rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= fin_r;
    end
  end

endmodule

>>> src/look_at_view_matrix_unit.sv
// throughput: one view setup per cycle while the back does not stall; the back pipeline is
// a single stalling pipeline sized by the square root (one bit per stage) and divide stages
// reset: synchronous active low, empties the queues and clears all valid flags;
// datapath registers are not reset and no clearing pass is needed
// uses lav_pkg, lav_front, lav_fifo, lav_back (lav_norm inside)
module look_at_view_matrix_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  lav_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output lav_pkg::out_item_t out_item
);
  import lav_pkg::*;

  // front to queue
  logic mid_push, mid_full;
  mid_t mid_wr;
  // queue to back
  logic mid_pop, mid_empty;
  mid_t mid_rd;

  // front: takes the transfer, forms target minus eye, widens the up vector
  lav_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .mid_push (mid_push),
    .mid_item (mid_wr),
    .mid_full (mid_full)
  );

  // short queue so the front keeps taking items while the back stalls
  lav_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (mid_push),
    .wr_item (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_item (mid_rd),
    .empty   (mid_empty)
  );

  // back: normalize up and forward, side = f x n normalized, up = s x f,
  // translations from the eye, then the result queue
  lav_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_item  (mid_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

>>> src/lav_checker.sv
// lav_checker: port-level assertions for look_at_view_matrix_unit and the
// bind that attaches them; uses lav_pkg
module lav_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_push,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input lav_pkg::out_item_t out_item
);
  import lav_pkg::*;

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_item))
    else $error("waiting result changed");

  // input side only fills up after a transfer in
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("full rose without a transfer");

  // no result can appear right after reset
  a_no_early: assert property (@(posedge clk)
    !rst_n |=> ##1 out_empty)
    else $error("result too soon after reset");

endmodule

bind look_at_view_matrix_unit lav_checker u_lav_checker (.*);
